[design/ptcb_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic timer channel bank package
// Shared sizes, request codes and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptcb_pkg;

  // Number of timer channels and width of each counter.
  localparam int CHANNELS   = 8;
  localparam int COUNT_BITS = 16;

  // Width of a channel index inside the bank.
  localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field widths of the item ports.
  localparam int REQ_BITS  = 4;
  localparam int CH_BITS   = 3;
  localparam int IVAL_BITS = 16;
  localparam int MASK_BITS = 8;

  // Request codes.
  typedef enum logic [REQ_BITS-1:0] {
    REQ_TICK        = 4'd0,
    REQ_ASSIGN      = 4'd1,
    REQ_ASSIGN_FREE = 4'd2,
    REQ_UNASSIGN    = 4'd3,
    REQ_DISABLE     = 4'd4,
    REQ_ENABLE      = 4'd5,
    REQ_UNHOLD      = 4'd6,
    REQ_SET_IVAL    = 4'd7,
    REQ_QUERY       = 4'd8
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture a new request and clear the result
    logic step;      // carry out the request on the selected channel
    logic out_load;  // copy the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last; // the current step finishes the request
  } stat_t;

endpackage

[design/ptcb_ctrl.sv]
// ----------------------------------------------------------------------------
// Periodic timer channel bank controller
// Sequences one item at a time: capture, channel steps, then hand-over to
// the output register once that register is free.
// ----------------------------------------------------------------------------
module ptcb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  ptcb_pkg::stat_t stat,
  output ptcb_pkg::cmd_t  cmd
);
  import ptcb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // Commands follow directly from the state and the handshakes.
  always_comb begin
    cmd.load_req = (state == S_IDLE) && in_valid;
    cmd.step     = (state == S_RUN);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  assign in_stall = (state != S_IDLE);

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new result is loaded, or a taken one leaves the output register.
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (stat.step_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/ptcb_datapath.sv]
// ----------------------------------------------------------------------------
// Periodic timer channel bank datapath
// Holds the channel state, the captured request, the sweep index, the
// result being built and the output register.
// ----------------------------------------------------------------------------
module ptcb_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  ptcb_pkg::cmd_t                 cmd,
  output ptcb_pkg::stat_t                stat,
  input  logic [ptcb_pkg::REQ_BITS-1:0]  req_type,
  input  logic [ptcb_pkg::CH_BITS-1:0]   channel,
  input  logic [ptcb_pkg::IVAL_BITS-1:0] interval,
  input  logic                           start_active,
  input  logic                           handler_present,
  output logic [ptcb_pkg::MASK_BITS-1:0] fired_mask,
  output logic                           found,
  output logic [ptcb_pkg::CH_BITS-1:0]   granted_channel,
  output logic                           is_active,
  output logic [ptcb_pkg::IVAL_BITS-1:0] current_interval
);
  import ptcb_pkg::*;

  // Channel state.
  logic [COUNT_BITS-1:0] reload_value [CHANNELS];
  logic [COUNT_BITS-1:0] down_count   [CHANNELS];
  logic [CHANNELS-1:0]   active_flag;
  logic [CHANNELS-1:0]   assigned_flag;

  // Captured request.
  req_t                 req_q;
  logic [CH_BITS-1:0]   ch_q;
  logic [IVAL_BITS-1:0] ival_q;
  logic                 act_q;
  logic                 hnd_q;

  // Sweep index and result under construction.
  logic [IDX_BITS-1:0]  idx;
  logic [MASK_BITS-1:0] fired_acc;
  logic                 found_acc;
  logic [CH_BITS-1:0]   granted_acc;
  logic                 qact_acc;
  logic [IVAL_BITS-1:0] qint_acc;

  logic                  sweep;
  logic                  ch_ok;
  logic                  idx_last;
  logic [IDX_BITS-1:0]   sel;
  logic [COUNT_BITS-1:0] cur_rel;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  cur_act;
  logic                  cur_asg;
  logic [MASK_BITS-1:0]  fire_bit;

  // Tick and assign-free walk the channels; everything else uses one channel.
  assign sweep    = (req_q == REQ_TICK) || (req_q == REQ_ASSIGN_FREE);
  assign ch_ok    = (int'(ch_q) < CHANNELS);
  assign idx_last = (idx == IDX_BITS'(CHANNELS - 1));
  assign sel      = sweep ? idx : IDX_BITS'(ch_q);

  // Single read port on the channel state.
  assign cur_rel = reload_value[sel];
  assign cur_cnt = down_count[sel];
  assign cur_act = active_flag[sel];
  assign cur_asg = assigned_flag[sel];

  // Fired mask bit for the channel under the sweep index, if it is visible.
  always_comb begin
    fire_bit = '0;
    for (int b = 0; b < MASK_BITS; b++) begin
      if ((b < CHANNELS) && (idx == IDX_BITS'(b))) begin
        fire_bit[b] = 1'b1;
      end
    end
  end

  // The step ends the request when it is a single-channel request, the
  // sweep has reached the last channel, or assign-free has found a slot.
  always_comb begin
    stat.step_last = !sweep || idx_last ||
                     ((req_q == REQ_ASSIGN_FREE) && !cur_asg);
  end

  // Request capture, sweep index and result accumulation.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q       <= req_t'(req_type);
      ch_q        <= channel;
      ival_q      <= interval;
      act_q       <= start_active;
      hnd_q       <= handler_present;
      idx         <= '0;
      fired_acc   <= '0;
      found_acc   <= 1'b0;
      granted_acc <= '0;
      qact_acc    <= 1'b0;
      qint_acc    <= '0;
    end else if (cmd.step) begin
      if (!idx_last) begin
        idx <= idx + IDX_BITS'(1);
      end
      unique case (req_q)
        REQ_TICK: begin
          if (cur_act && cur_asg && (cur_cnt == '0)) begin
            fired_acc <= fired_acc | fire_bit;
          end
        end
        REQ_ASSIGN_FREE: begin
          if (!cur_asg) begin
            found_acc   <= 1'b1;
            granted_acc <= CH_BITS'(idx);
          end
        end
        REQ_QUERY: begin
          if (ch_ok) begin
            qact_acc <= cur_act;
            qint_acc <= IVAL_BITS'(cur_rel);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Channel state updates, one channel per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        reload_value[i] <= '0;
        down_count[i]   <= '0;
      end
      active_flag   <= '0;
      assigned_flag <= '0;
    end else if (cmd.step) begin
      unique case (req_q)
        REQ_TICK: begin
          if (cur_act && cur_asg) begin
            if (cur_cnt == '0) begin
              down_count[sel] <= cur_rel;
            end else begin
              down_count[sel] <= cur_cnt - COUNT_BITS'(1);
            end
          end
        end
        REQ_ASSIGN_FREE: begin
          if (!cur_asg) begin
            reload_value[sel]  <= COUNT_BITS'(ival_q);
            down_count[sel]    <= '0;
            active_flag[sel]   <= act_q;
            assigned_flag[sel] <= hnd_q;
          end
        end
        REQ_ASSIGN: begin
          if (ch_ok) begin
            reload_value[sel]  <= COUNT_BITS'(ival_q);
            down_count[sel]    <= '0;
            active_flag[sel]   <= act_q;
            assigned_flag[sel] <= hnd_q;
          end
        end
        REQ_UNASSIGN: begin
          if (ch_ok) begin
            reload_value[sel]  <= '0;
            down_count[sel]    <= '0;
            active_flag[sel]   <= 1'b0;
            assigned_flag[sel] <= 1'b0;
          end
        end
        REQ_DISABLE: begin
          if (ch_ok) begin
            active_flag[sel] <= 1'b0;
          end
        end
        REQ_ENABLE: begin
          if (ch_ok) begin
            active_flag[sel] <= 1'b1;
            down_count[sel]  <= '0;
          end
        end
        REQ_UNHOLD: begin
          if (ch_ok) begin
            active_flag[sel] <= 1'b1;
          end
        end
        REQ_SET_IVAL: begin
          if (ch_ok) begin
            reload_value[sel] <= COUNT_BITS'(ival_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register, loaded only when the receiver side is free.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fired_mask       <= fired_acc;
      found            <= found_acc;
      granted_channel  <= granted_acc;
      is_active        <= qact_acc;
      current_interval <= qint_acc;
    end
  end

endmodule

[design/periodic_timer_channel_bank.sv]
// ----------------------------------------------------------------------------
// Periodic timer channel bank
// A bank of programmable periodic timer channels driven by request items.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in channel (in_valid, in_stall) carrying req_type,
// channel, interval, start_active and handler_present. Every request gives
// exactly one result item on the out channel (out_valid, out_stall) with
// fired_mask, found, granted_channel, is_active and current_interval; fields
// that do not belong to the request read as zero.
// A tick walks the channels (eight here) one per cycle; assign-free walks
// until the lowest free channel is found. All other requests work on the
// selected channel alone. A new item can be taken in the cycle after the
// result is handed to the output register.
// The block handles one item at a time and stalls the input while it works.
// If the receiver stalls, the result is held in the output register and a
// following item still runs, waiting only at hand-over.
// Reset clears every channel to unassigned, inactive, interval and counter
// zero, and leaves both channels empty.
// ----------------------------------------------------------------------------
module periodic_timer_channel_bank (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptcb_pkg::REQ_BITS-1:0]  req_type,
  input  logic [ptcb_pkg::CH_BITS-1:0]   channel,
  input  logic [ptcb_pkg::IVAL_BITS-1:0] interval,
  input  logic                           start_active,
  input  logic                           handler_present,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ptcb_pkg::MASK_BITS-1:0] fired_mask,
  output logic                           found,
  output logic [ptcb_pkg::CH_BITS-1:0]   granted_channel,
  output logic                           is_active,
  output logic [ptcb_pkg::IVAL_BITS-1:0] current_interval
);
  import ptcb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of each item.
  ptcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Channel state and result path.
  ptcb_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .req_type         (req_type),
    .channel          (channel),
    .interval         (interval),
    .start_active     (start_active),
    .handler_present  (handler_present),
    .fired_mask       (fired_mask),
    .found            (found),
    .granted_channel  (granted_channel),
    .is_active        (is_active),
    .current_interval (current_interval)
  );

endmodule

[design/ptcb_checker.sv]
// ----------------------------------------------------------------------------
// Periodic timer channel bank checker
// Port-level properties of the bank, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ptcb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ptcb_pkg::MASK_BITS-1:0] fired_mask,
  input logic                           found,
  input logic [ptcb_pkg::CH_BITS-1:0]   granted_channel,
  input logic                           is_active,
  input logic [ptcb_pkg::IVAL_BITS-1:0] current_interval
);
  import ptcb_pkg::*;

  // A held result stays valid and keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fired_mask) && $stable(found) &&
      $stable(granted_channel) && $stable(is_active) && $stable(current_interval))
    else $error("held result changed");

  // The bank works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled while an item is in work");

  // A tick result carries nothing from the other request kinds.
  a_tick_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fired_mask != '0) |->
      !found && !is_active && (current_interval == '0) && (granted_channel == '0))
    else $error("tick result mixed with another request's fields");

  // A channel is only granted when one was found.
  a_grant_needs_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> (granted_channel == '0))
    else $error("channel granted without a find");

endmodule

bind periodic_timer_channel_bank ptcb_checker u_ptcb_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .fired_mask       (fired_mask),
  .found            (found),
  .granted_channel  (granted_channel),
  .is_active        (is_active),
  .current_interval (current_interval)
);

[test/tb.sv]
// ----------------------------------------------------------------------------
// Periodic timer channel bank testbench
// Drives request items into the bank and keeps its own model of every
// channel's interval, down counter, active flag and assigned flag. Each
// accepted request is turned into an expected result. Each result the block
// hands out is compared field by field with the oldest expected result.
// Directed requests come first. A flat-out phase and a long output hold-off
// follow, and then a long run of random requests.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptcb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;

  // One result item as the bank reports it.
  typedef struct packed {
    logic [MASK_BITS-1:0] fired_mask;
    logic                 found;
    logic [CH_BITS-1:0]   granted_channel;
    logic                 is_active;
    logic [IVAL_BITS-1:0] current_interval;
  } bank_resp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_BITS-1:0]  req_type = '0;
  logic [CH_BITS-1:0]   channel = '0;
  logic [IVAL_BITS-1:0] interval = '0;
  logic                 start_active = 1'b0;
  logic                 handler_present = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MASK_BITS-1:0] fired_mask;
  logic                 found;
  logic [CH_BITS-1:0]   granted_channel;
  logic                 is_active;
  logic [IVAL_BITS-1:0] current_interval;

  // Model of the channel bank.
  logic [COUNT_BITS-1:0] chan_reload [CHANNELS];
  logic [COUNT_BITS-1:0] chan_count  [CHANNELS];
  logic                  chan_active [CHANNELS];
  logic                  chan_owned  [CHANNELS];

  bank_resp_t due_results [$];
  bank_resp_t oldest_due;
  int         fail_count = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 33;
  int         rx_idle_pct = 33;
  int         hold_left = 0;
  bit         hold_req = 1'b0;

  periodic_timer_channel_bank dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .channel          (channel),
    .interval         (interval),
    .start_active     (start_active),
    .handler_present  (handler_present),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .fired_mask       (fired_mask),
    .found            (found),
    .granted_channel  (granted_channel),
    .is_active        (is_active),
    .current_interval (current_interval)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Applies one request to the model bank and returns the result it gives.
  function automatic bank_resp_t advance_bank(logic [REQ_BITS-1:0] code,
                                              logic [CH_BITS-1:0] ch,
                                              logic [IVAL_BITS-1:0] ival,
                                              logic act, logic hnd);
    bank_resp_t resp;
    bit         taken;
    resp  = '0;
    taken = 1'b0;
    case (code)
      REQ_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (chan_active[i] && chan_owned[i]) begin
            if (chan_count[i] == '0) begin
              chan_count[i] = chan_reload[i];
              if (i < MASK_BITS) resp.fired_mask[i] = 1'b1;
            end else begin
              chan_count[i] = chan_count[i] - 1'b1;
            end
          end
        end
      end
      REQ_ASSIGN: begin
        chan_reload[ch] = COUNT_BITS'(ival);
        chan_count[ch]  = '0;
        chan_active[ch] = act;
        chan_owned[ch]  = hnd;
      end
      REQ_ASSIGN_FREE: begin
        // The lowest channel without an owner is taken.
        for (int i = 0; i < CHANNELS; i++) begin
          if (!taken && !chan_owned[i]) begin
            chan_reload[i] = COUNT_BITS'(ival);
            chan_count[i]  = '0;
            chan_active[i] = act;
            chan_owned[i]  = hnd;
            resp.found           = 1'b1;
            resp.granted_channel = CH_BITS'(i);
            taken = 1'b1;
          end
        end
      end
      REQ_UNASSIGN: begin
        chan_reload[ch] = '0;
        chan_count[ch]  = '0;
        chan_active[ch] = 1'b0;
        chan_owned[ch]  = 1'b0;
      end
      REQ_DISABLE: chan_active[ch] = 1'b0;
      REQ_ENABLE: begin
        chan_active[ch] = 1'b1;
        chan_count[ch]  = '0;
      end
      REQ_UNHOLD:   chan_active[ch] = 1'b1;
      REQ_SET_IVAL: chan_reload[ch] = COUNT_BITS'(ival);
      REQ_QUERY: begin
        resp.is_active        = chan_active[ch];
        resp.current_interval = IVAL_BITS'(chan_reload[ch]);
      end
      default: ;
    endcase
    return resp;
  endfunction

  // Offers one item, holds it until accepted and records what it should give.
  task automatic send_req(logic [REQ_BITS-1:0] code, logic [CH_BITS-1:0] ch,
                          logic [IVAL_BITS-1:0] ival, logic act, logic hnd);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= code;
    channel         <= ch;
    interval        <= ival;
    start_active    <= act;
    handler_present <= hnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_results.push_back(advance_bank(code, ch, ival, act, hnd));
  endtask

  // Random request, weighted towards ticks and short intervals so that
  // channels fire often; a few unknown codes are mixed in as noise.
  task automatic send_random_req();
    int                   pick;
    int                   sel;
    logic [REQ_BITS-1:0]  code;
    logic [IVAL_BITS-1:0] ival;
    pick = $urandom_range(0, 99);
    if (pick < 35)      code = REQ_TICK;
    else if (pick < 47) code = REQ_ASSIGN;
    else if (pick < 57) code = REQ_ASSIGN_FREE;
    else if (pick < 64) code = REQ_UNASSIGN;
    else if (pick < 71) code = REQ_DISABLE;
    else if (pick < 78) code = REQ_ENABLE;
    else if (pick < 85) code = REQ_UNHOLD;
    else if (pick < 92) code = REQ_SET_IVAL;
    else if (pick < 98) code = REQ_QUERY;
    else                code = REQ_BITS'($urandom_range(REQ_QUERY + 1, 15));
    sel = $urandom_range(0, 9);
    if (sel < 7)       ival = IVAL_BITS'($urandom_range(0, 6));
    else if (sel == 7) ival = '1;
    else               ival = IVAL_BITS'($urandom);
    send_req(code, CH_BITS'($urandom_range(0, 7)), ival,
             $urandom_range(0, 4) != 0, $urandom_range(0, 6) != 0);
  endtask

  // Compares one field of a result.
  function automatic void check_field(string name, logic [IVAL_BITS-1:0] want,
                                      logic [IVAL_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Receiver: checks each result item taken and drives the stall, with a
  // long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result item with nothing outstanding, fired_mask %0h", fired_mask);
          fail_count++;
        end else begin
          oldest_due = due_results.pop_front();
          check_field("fired_mask", IVAL_BITS'(oldest_due.fired_mask),
                      IVAL_BITS'(fired_mask));
          check_field("found", IVAL_BITS'(oldest_due.found), IVAL_BITS'(found));
          check_field("granted_channel", IVAL_BITS'(oldest_due.granted_channel),
                      IVAL_BITS'(granted_channel));
          check_field("is_active", IVAL_BITS'(oldest_due.is_active),
                      IVAL_BITS'(is_active));
          check_field("current_interval", oldest_due.current_interval,
                      current_interval);
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // Every request kind at the extremes of channel and interval, including
  // a missing handler, a full bank and unknown codes.
  task automatic test_directed();
    tx_idle_pct = 33;
    rx_idle_pct = 33;
    send_req(REQ_QUERY, 3'd5, 16'h1234, 1'b1, 1'b1);
    send_req(REQ_TICK, 3'd0, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_ASSIGN, 3'd0, 16'h0000, 1'b1, 1'b1);
    send_req(REQ_ASSIGN, 3'd7, 16'hFFFF, 1'b1, 1'b1);
    send_req(REQ_TICK, 3'd7, 16'hFFFF, 1'b1, 1'b1);
    send_req(REQ_TICK, 3'd0, 16'h0000, 1'b0, 1'b0);
    // Without a handler the channel is written but stays free.
    send_req(REQ_ASSIGN, 3'd3, 16'd2, 1'b1, 1'b0);
    send_req(REQ_ASSIGN_FREE, 3'd6, 16'd5, 1'b1, 1'b0);
    send_req(REQ_ASSIGN_FREE, 3'd2, 16'd1, 1'b1, 1'b1);
    send_req(REQ_DISABLE, 3'd0, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_TICK, 3'd0, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_UNHOLD, 3'd0, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_ENABLE, 3'd7, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_TICK, 3'd0, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_SET_IVAL, 3'd7, 16'h8000, 1'b0, 1'b0);
    send_req(REQ_QUERY, 3'd7, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_QUERY, 3'd3, 16'hFFFF, 1'b1, 1'b1);
    // Unknown codes change nothing and give an all-zero result.
    send_req(REQ_BITS'(REQ_QUERY + 1), 3'd7, 16'hFFFF, 1'b1, 1'b1);
    send_req(4'hF, 3'd7, 16'hFFFF, 1'b1, 1'b1);
    send_req(REQ_UNASSIGN, 3'd1, 16'hFFFF, 1'b1, 1'b1);
    send_req(REQ_QUERY, 3'd1, 16'h0000, 1'b0, 1'b0);
    send_req(REQ_ASSIGN_FREE, 3'd0, 16'd3, 1'b0, 1'b1);
    // Fill the bank, then ask for a free channel when there is none.
    for (int c = 2; c <= 6; c++) send_req(REQ_ASSIGN, CH_BITS'(c), 16'(c), 1'b1, 1'b1);
    send_req(REQ_ASSIGN_FREE, 3'd4, 16'd9, 1'b1, 1'b1);
    send_req(REQ_TICK, 3'd0, 16'h0000, 1'b0, 1'b0);
  endtask

  // Back-to-back items with neither side idling.
  task automatic test_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (50) send_random_req();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the block fills up and stalls its input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (30) send_random_req();
  endtask

  // Long random run with idling on both sides.
  task automatic test_random();
    tx_idle_pct = 33;
    rx_idle_pct = 33;
    repeat (300) send_random_req();
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      chan_reload[i] = '0;
      chan_count[i]  = '0;
      chan_active[i] = 1'b0;
      chan_owned[i]  = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_idle();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    // Wait for every outstanding result, then a little longer for strays.
    while (due_results.size() != 0) @(posedge clk);
    repeat (CHANNELS + 8) @(posedge clk);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ptcb_pkg.sv
design/ptcb_ctrl.sv
design/ptcb_datapath.sv
design/periodic_timer_channel_bank.sv
design/ptcb_checker.sv
test/tb.sv
